>>> sv/sdt_pkg.sv
// ============================================================================
// sdt_pkg: shared types and constants of the sighting deduplication table
// Holds the register indexes, reset values, default sizes and the sequencer
// state type used by the table and its top level.
// ============================================================================
`default_nettype none

package sdt_pkg;

    // Default sizes of the table.
    localparam int ENTRIES_DEF  = 128;
    localparam int KEY_BITS_DEF = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRACE  = CFG_IDX_W'(1);

    // Register values after reset.
    localparam logic [31:0] WINDOW_RESET = 32'd1800000;
    localparam logic [31:0] GRACE_RESET  = 32'd20000;

    // Tick width.
    localparam int TICK_W = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEC1,
        ST_DEC2,
        ST_FIN
    } t_state;

endpackage : sdt_pkg

`default_nettype wire

>>> sv/sdt_ram.sv
// ============================================================================
// sdt_ram: generic single write port, single read port RAM
// One write and one registered read per cycle; width and depth are parameters.
// ============================================================================
`default_nettype none

module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : sdt_ram

`default_nettype wire

>>> sv/sighting_dedup_table_top.sv
// ============================================================================
// sighting_dedup_table_top: time-window deduplication table for sightings
// Looks each sighting up in a table of keys by a sequential scan and answers
// whether a record should be written now, holding back sightings that wait
// for their route and silencing keys logged within the window.
// ============================================================================
//
//  Channel   | Direction | Handshake                     | Contents
//  ----------+-----------+-------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | one sighting per word
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | one log decision per word
//  cfg       | in        | i_cfg_we (no wait)            | window and grace registers
//
//  An item occupies the block from one accept to the next for a scan of the
//  table, the decision steps and the hand-off of its decision; a key found in
//  a slot ends the scan there. The table memory is read one slot per cycle.
//  Reset is synchronous and active low; it clears the per-slot valid bits, so
//  no clearing pass over the memory is needed. A stalled output only delays the
//  end of the next item: the following word may be accepted while a decision
//  still waits in the output register.
// ============================================================================
`default_nettype none

module sighting_dedup_table_top #(
    parameter int ENTRIES  = sdt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = sdt_pkg::KEY_BITS_DEF,
    localparam int IN_W    = ((KEY_BITS + 2 * 16 + 2 + 7) / 8) * 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Sighting: aircraft_key, now_ticks, has_callsign, route_known, zero pad.
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [IN_W-1:0]                s_axis_tdata,
    // Decision: log_now, zero pad.
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [7:0]                     m_axis_tdata,
    // Configuration writes.
    input  wire logic                           i_cfg_we,
    input  wire logic [sdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sdt_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TW     = sdt_pkg::TICK_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // Memory word: pending mark, first-seen time, logged time, key (low to high).
    localparam int MEM_W  = KEY_BITS + 2 * TW + 1;
    localparam int FST_LO = 1;
    localparam int LOG_LO = 1 + TW;
    localparam int KEY_LO = 1 + 2 * TW;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // ------------------------------------------------------------------------
    // Input word fields.
    // ------------------------------------------------------------------------
    logic [KEY_BITS-1:0] in_key;
    logic [TW-1:0]       in_now;
    logic                in_cs;
    logic                in_rt;

    assign in_key = s_axis_tdata[KEY_BITS-1:0];
    assign in_now = s_axis_tdata[KEY_BITS +: TW];
    assign in_cs  = s_axis_tdata[KEY_BITS + TW];
    assign in_rt  = s_axis_tdata[KEY_BITS + TW + 1];

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    sdt_pkg::t_state     r_state, n_state;
    logic                r_issue, n_issue;
    logic                r_chk_en, n_chk_en;
    logic                r_have, n_have;
    logic                r_out_valid, n_out_valid;
    logic [ENTRIES-1:0]  r_valid;
    logic [TW-1:0]       r_window, r_grace;

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TW-1:0]       r_now, n_now;
    logic                r_cs, n_cs;
    logic                r_rt, n_rt;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]    r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]    r_pick, n_pick;
    logic [IDX_W-1:0]    r_slot, n_slot;
    logic [TW-1:0]       r_e_log, n_e_log;
    logic [TW-1:0]       r_e_first, n_e_first;
    logic                r_e_pend, n_e_pend;
    logic                r_log, n_log;
    logic                r_out_log, n_out_log;

    // ------------------------------------------------------------------------
    // Table memory and the entry as seen through its valid bit. A slot never
    // written reads as empty with zero times and no pending mark.
    // ------------------------------------------------------------------------
    logic                ram_we;
    logic [MEM_W-1:0]    ram_wdata;
    logic [MEM_W-1:0]    ram_rdata;
    logic                e_vld;
    logic [KEY_BITS-1:0] e_key;
    logic [TW-1:0]       e_log;
    logic [TW-1:0]       e_first;
    logic                e_pend;

    sdt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign e_vld   = r_valid[r_chk_idx];
    assign e_key   = e_vld ? ram_rdata[KEY_LO +: KEY_BITS] : '0;
    assign e_log   = e_vld ? ram_rdata[LOG_LO +: TW] : '0;
    assign e_first = e_vld ? ram_rdata[FST_LO +: TW] : '0;
    assign e_pend  = e_vld & ram_rdata[0];

    // ------------------------------------------------------------------------
    // The shared unit: one wrapping subtract from the current tick and one
    // compare. During the scan it tests each slot for an elapsed window; in
    // the decision steps it tests the window and then the grace time.
    // ------------------------------------------------------------------------
    logic [TW-1:0] u_op_a;
    logic [TW-1:0] u_op_b;
    logic [TW-1:0] u_diff;
    logic          u_ge;

    always_comb begin
        case (r_state)
            sdt_pkg::ST_SCAN: begin
                u_op_a = e_log;
                u_op_b = r_window;
            end
            sdt_pkg::ST_DEC1: begin
                u_op_a = r_e_log;
                u_op_b = r_window;
            end
            default: begin
                u_op_a = r_e_first;
                u_op_b = r_grace;
            end
        endcase
        u_diff = r_now - u_op_a;
        u_ge   = (u_diff >= u_op_b);
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state and datapath updates.
    // ------------------------------------------------------------------------
    logic hit;
    logic cand;

    assign hit  = (e_key != '0) && (e_key == r_key);
    assign cand = (e_key == '0) || (!e_pend && u_ge);

    assign s_axis_tready = (r_state == sdt_pkg::ST_IDLE);
    // The entry is written back with the outcome of the final decision step.
    assign ram_wdata     = {r_key, n_e_log, n_e_first, n_e_pend};

    always_comb begin
        n_state     = r_state;
        n_issue     = r_issue;
        n_chk_en    = 1'b0;
        n_have      = r_have;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_key       = r_key;
        n_now       = r_now;
        n_cs        = r_cs;
        n_rt        = r_rt;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_pick      = r_pick;
        n_slot      = r_slot;
        n_e_log     = r_e_log;
        n_e_first   = r_e_first;
        n_e_pend    = r_e_pend;
        n_log       = r_log;
        n_out_log   = r_out_log;
        ram_we      = 1'b0;

        case (r_state)
            sdt_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_key    = in_key;
                    n_now    = in_now;
                    n_cs     = in_cs;
                    n_rt     = in_rt;
                    n_rd_idx = '0;
                    n_issue  = 1'b1;
                    n_have   = 1'b0;
                    n_state  = sdt_pkg::ST_SCAN;
                end
            end

            sdt_pkg::ST_SCAN: begin
                // Issue the next slot read; its data is checked in the next cycle.
                if (r_issue) begin
                    n_chk_en  = 1'b1;
                    n_chk_idx = r_rd_idx;
                    if (r_rd_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                end
                if (r_chk_en) begin
                    if (!r_have && cand) begin
                        n_have = 1'b1;
                        n_pick = r_chk_idx;
                    end
                    if (hit) begin
                        // A matching slot is used as it stands.
                        n_slot    = r_chk_idx;
                        n_e_log   = e_log;
                        n_e_first = e_first;
                        n_e_pend  = e_pend;
                        n_issue   = 1'b0;
                        n_chk_en  = 1'b0;
                        n_state   = sdt_pkg::ST_DEC1;
                    end else if (r_chk_idx == LAST_IDX) begin
                        // No match: claim the first free or expired slot,
                        // or slot zero when there is none.
                        if (r_have) begin
                            n_slot = r_pick;
                        end else if (cand) begin
                            n_slot = r_chk_idx;
                        end else begin
                            n_slot = '0;
                        end
                        n_e_log   = '0;
                        n_e_first = r_now;
                        n_e_pend  = 1'b1;
                        n_state   = sdt_pkg::ST_DEC1;
                    end
                end
            end

            sdt_pkg::ST_DEC1: begin
                if (!r_e_pend) begin
                    if (!u_ge) begin
                        // Logged within the window: stay silent, no change.
                        n_log   = 1'b0;
                        n_state = sdt_pkg::ST_FIN;
                    end else begin
                        n_e_pend  = 1'b1;
                        n_e_first = r_now;
                        n_state   = sdt_pkg::ST_DEC2;
                    end
                end else begin
                    n_state = sdt_pkg::ST_DEC2;
                end
            end

            sdt_pkg::ST_DEC2: begin
                ram_we = 1'b1;
                if (r_cs && !r_rt && !u_ge) begin
                    // Still waiting for the route within the grace time.
                    n_log = 1'b0;
                end else begin
                    n_log    = 1'b1;
                    n_e_pend = 1'b0;
                    n_e_log  = r_now;
                end
                n_state = sdt_pkg::ST_FIN;
            end

            sdt_pkg::ST_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_log   = r_log;
                    n_state     = sdt_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = sdt_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdt_pkg::ST_IDLE;
            r_issue     <= 1'b0;
            r_chk_en    <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_window    <= sdt_pkg::WINDOW_RESET;
            r_grace     <= sdt_pkg::GRACE_RESET;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_chk_en    <= n_chk_en;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdt_pkg::REG_WINDOW: r_window <= i_cfg_data;
                    sdt_pkg::REG_GRACE:  r_grace  <= i_cfg_data;
                    default: begin
                        // Writes to unused indexes are dropped.
                    end
                endcase
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_now     <= n_now;
        r_cs      <= n_cs;
        r_rt      <= n_rt;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_pick    <= n_pick;
        r_slot    <= n_slot;
        r_e_log   <= n_e_log;
        r_e_first <= n_e_first;
        r_e_pend  <= n_e_pend;
        r_log     <= n_log;
        r_out_log <= n_out_log;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out_log};

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // An accepted word always starts a scan.
    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == sdt_pkg::ST_SCAN))
        else $error("accepted word did not start a scan");

    // The table is written only in the final decision step.
    a_write_in_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == sdt_pkg::ST_DEC2))
        else $error("table write outside the decision step");

    // A new decision appears only when the sequencer finishes an item.
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == sdt_pkg::ST_FIN))
        else $error("output word without a finished item");

    // A pending read check only happens during the scan.
    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_en |-> (r_state == sdt_pkg::ST_SCAN))
        else $error("slot check outside the scan");

endmodule : sighting_dedup_table_top

`default_nettype wire
